>>> rtl/tsl_pkg.sv
// Shared mark codes, field widths, default depths and the result type of the segment logger.
`default_nettype none
package tsl_pkg;

  localparam int unsigned MARK_W   = 3;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned XCNT_W   = 7;
  localparam int unsigned XSLOT_W  = 6;
  localparam int unsigned XSEG_W   = 9;
  localparam int unsigned ENDCNT_W = 8;

  localparam int unsigned RECORD_DEPTH_DEF = 256;
  localparam int unsigned CROSS_DEPTH_DEF  = 64;

  localparam logic [MARK_W-1:0] TRACK_NONE     = 3'd0;
  localparam logic [MARK_W-1:0] TRACK_STRAIGHT = 3'd1;
  localparam logic [MARK_W-1:0] TRACK_LEFT     = 3'd2;
  localparam logic [MARK_W-1:0] TRACK_RIGHT    = 3'd3;
  localparam logic [MARK_W-1:0] TRACK_CROSSING = 3'd4;
  localparam logic [MARK_W-1:0] TRACK_FINISH   = 3'd5;
  localparam logic [MARK_W-1:0] TRACK_LOST     = 3'd6;
  localparam logic [MARK_W-1:0] MARK_INVALID   = 3'd7;

  localparam logic [ENDCNT_W-1:0] END_COUNT_MAX = '1;
  localparam logic [ENDCNT_W-1:0] END_COUNT_LOG = 8'd2;

  typedef struct packed {
    logic                 record_write;
    logic [SLOT_W-1:0]    record_slot;
    logic [COUNT_W-1:0]   left_delta;
    logic [COUNT_W-1:0]   right_delta;
    logic [XCNT_W-1:0]    crossings_at_close;
    logic                 cross_write;
    logic [XSLOT_W-1:0]   cross_slot;
    logic [XSEG_W-1:0]    cross_segment;
    logic [MARK_W-1:0]    effective_mark;
    logic [ENDCNT_W-1:0]  end_marks_seen;
    logic                 overflow;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/tsl_if.sv
// Valid/ready channel interfaces for sample input and segment log output.
`default_nettype none
interface tsl_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsl_pkg::MARK_W-1:0]    mark_in;
  logic [tsl_pkg::COUNT_W-1:0]   left_count;
  logic [tsl_pkg::COUNT_W-1:0]   right_count;

  modport source (output valid, output mark_in, output left_count, output right_count,
                  input ready);
  modport sink   (input valid, input mark_in, input left_count, input right_count,
                  output ready);
endinterface

interface tsl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          record_write;
  logic [tsl_pkg::SLOT_W-1:0]    record_slot;
  logic [tsl_pkg::COUNT_W-1:0]   left_delta;
  logic [tsl_pkg::COUNT_W-1:0]   right_delta;
  logic [tsl_pkg::XCNT_W-1:0]    crossings_at_close;
  logic                          cross_write;
  logic [tsl_pkg::XSLOT_W-1:0]   cross_slot;
  logic [tsl_pkg::XSEG_W-1:0]    cross_segment;
  logic [tsl_pkg::MARK_W-1:0]    effective_mark;
  logic [tsl_pkg::ENDCNT_W-1:0]  end_marks_seen;
  logic                          overflow;

  modport source (output valid, output record_write, output record_slot,
                  output left_delta, output right_delta, output crossings_at_close,
                  output cross_write, output cross_slot, output cross_segment,
                  output effective_mark, output end_marks_seen, output overflow,
                  input ready);
  modport sink   (input valid, input record_write, input record_slot,
                  input left_delta, input right_delta, input crossings_at_close,
                  input cross_write, input cross_slot, input cross_segment,
                  input effective_mark, input end_marks_seen, input overflow,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/tsl_step.sv
// Next-state and result logic for one sample of the segment logger.
`default_nettype none
module tsl_step #(
  parameter int unsigned RECORD_DEPTH = tsl_pkg::RECORD_DEPTH_DEF,
  parameter int unsigned CROSS_DEPTH  = tsl_pkg::CROSS_DEPTH_DEF,
  localparam int unsigned IDX_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1,
  localparam int unsigned XC_W  = $clog2(CROSS_DEPTH + 1)
) (
  input  wire logic [tsl_pkg::MARK_W-1:0]   mark_in,
  input  wire logic [tsl_pkg::COUNT_W-1:0]  left_count,
  input  wire logic [tsl_pkg::COUNT_W-1:0]  right_count,
  input  wire logic [IDX_W-1:0]             seg_idx,
  input  wire logic [tsl_pkg::MARK_W-1:0]   seg_mark,
  input  wire logic [tsl_pkg::COUNT_W-1:0]  left_start,
  input  wire logic [tsl_pkg::COUNT_W-1:0]  right_start,
  input  wire logic [XC_W-1:0]              cross_cnt,
  input  wire logic [tsl_pkg::ENDCNT_W-1:0] end_cnt,
  output logic [IDX_W-1:0]                  seg_idx_nxt,
  output logic [tsl_pkg::MARK_W-1:0]        seg_mark_nxt,
  output logic [tsl_pkg::COUNT_W-1:0]       left_start_nxt,
  output logic [tsl_pkg::COUNT_W-1:0]       right_start_nxt,
  output logic [XC_W-1:0]                   cross_cnt_nxt,
  output logic [tsl_pkg::ENDCNT_W-1:0]      end_cnt_nxt,
  output tsl_pkg::result_t                  result
);

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RECORD_DEPTH - 1);
  localparam logic [XC_W-1:0]  XC_LIMIT  = XC_W'(CROSS_DEPTH);

  logic                          ignore;
  logic                          is_cross;
  logic                          is_end;
  logic                          plain;
  logic [IDX_W:0]                idx_p1;
  logic [tsl_pkg::COUNT_W-1:0]   dl;
  logic [tsl_pkg::COUNT_W-1:0]   dr;

  assign ignore   = (mark_in == tsl_pkg::TRACK_LOST) || (mark_in == tsl_pkg::MARK_INVALID)
                    || (mark_in == seg_mark);
  assign is_cross = !ignore && (mark_in == tsl_pkg::TRACK_CROSSING);
  assign is_end   = !ignore && (mark_in == tsl_pkg::TRACK_FINISH);
  assign plain    = !ignore && !is_cross && !is_end;
  assign idx_p1   = {1'b0, seg_idx} + 1'b1;
  assign dl       = left_count - left_start;
  assign dr       = right_count - right_start;

  always_comb begin
    seg_idx_nxt     = seg_idx;
    seg_mark_nxt    = seg_mark;
    left_start_nxt  = left_start;
    right_start_nxt = right_start;
    cross_cnt_nxt   = cross_cnt;
    end_cnt_nxt     = end_cnt;
    result          = '0;
    result.effective_mark = mark_in;

    if (plain) begin
      result.record_write       = 1'b1;
      result.record_slot        = tsl_pkg::SLOT_W'(seg_idx);
      result.left_delta         = dl;
      result.right_delta        = dr;
      result.crossings_at_close = tsl_pkg::XCNT_W'(cross_cnt);
      if (seg_idx != IDX_LAST) begin
        seg_idx_nxt = idx_p1[IDX_W-1:0];
      end else begin
        result.overflow = 1'b1;
      end
      left_start_nxt  = left_count;
      right_start_nxt = right_count;
      seg_mark_nxt    = mark_in;
    end

    if (is_cross) begin
      result.effective_mark = seg_mark;
      if (cross_cnt < XC_LIMIT) begin
        result.cross_write   = 1'b1;
        result.cross_slot    = tsl_pkg::XSLOT_W'(cross_cnt);
        result.cross_segment = tsl_pkg::XSEG_W'(idx_p1);
        cross_cnt_nxt        = cross_cnt + 1'b1;
      end else begin
        result.overflow = 1'b1;
      end
    end

    if (is_end) begin
      result.effective_mark = seg_mark;
      if (end_cnt != tsl_pkg::END_COUNT_MAX) begin
        end_cnt_nxt = end_cnt + 1'b1;
      end
      // second and later end marks log the running segment in place
      if (end_cnt_nxt >= tsl_pkg::END_COUNT_LOG) begin
        result.record_write       = 1'b1;
        result.record_slot        = tsl_pkg::SLOT_W'(seg_idx);
        result.left_delta         = dl;
        result.right_delta        = dr;
        result.crossings_at_close = tsl_pkg::XCNT_W'(cross_cnt);
      end
    end

    result.end_marks_seen = end_cnt_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/track_segment_logger.sv
// Top level of the track segment logger: state registers, result register and handshake.
`default_nettype none
// Channel   Dir  Payload                                         Transaction
// in_ch     in   mark_in, left_count, right_count                one tick sample
// out_ch    out  record/crossing writes, deltas, mark, counters  one log entry per sample
//
// Each accepted sample yields exactly one log entry on the next cycle; one sample can be
// taken every cycle, set by the single subtract/compare stage between the sample and the
// result register. in_ch.ready is high whenever the result register is empty or is being
// drained in the same cycle, so a stalled output stops the input only while it holds a
// result. Synchronous active-low reset clears the segment index, marks, encoder starts,
// crossing and end counters and the result valid flag.
module track_segment_logger #(
  parameter int unsigned RECORD_DEPTH = tsl_pkg::RECORD_DEPTH_DEF,
  parameter int unsigned CROSS_DEPTH  = tsl_pkg::CROSS_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tsl_in_if.sink     in_ch,
  tsl_out_if.source  out_ch
);

  localparam int unsigned IDX_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int unsigned XC_W  = $clog2(CROSS_DEPTH + 1);

  // running segment state
  logic [IDX_W-1:0]              seg_idx_r,     seg_idx_nxt;
  logic [tsl_pkg::MARK_W-1:0]    seg_mark_r,    seg_mark_nxt;
  logic [tsl_pkg::COUNT_W-1:0]   left_start_r,  left_start_nxt;
  logic [tsl_pkg::COUNT_W-1:0]   right_start_r, right_start_nxt;
  logic [XC_W-1:0]               cross_cnt_r,   cross_cnt_nxt;
  logic [tsl_pkg::ENDCNT_W-1:0]  end_cnt_r,     end_cnt_nxt;

  // result register
  tsl_pkg::result_t  result_nxt;
  tsl_pkg::result_t  result_r;
  logic              out_valid_r;
  logic              in_take;

  // accept a sample when the result slot is free or emptying this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  tsl_step #(
    .RECORD_DEPTH (RECORD_DEPTH),
    .CROSS_DEPTH  (CROSS_DEPTH)
  ) u_step (
    .mark_in         (in_ch.mark_in),
    .left_count      (in_ch.left_count),
    .right_count     (in_ch.right_count),
    .seg_idx         (seg_idx_r),
    .seg_mark        (seg_mark_r),
    .left_start      (left_start_r),
    .right_start     (right_start_r),
    .cross_cnt       (cross_cnt_r),
    .end_cnt         (end_cnt_r),
    .seg_idx_nxt     (seg_idx_nxt),
    .seg_mark_nxt    (seg_mark_nxt),
    .left_start_nxt  (left_start_nxt),
    .right_start_nxt (right_start_nxt),
    .cross_cnt_nxt   (cross_cnt_nxt),
    .end_cnt_nxt     (end_cnt_nxt),
    .result          (result_nxt)
  );

  // advance segment state only on an accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_idx_r     <= '0;
      seg_mark_r    <= tsl_pkg::TRACK_NONE;
      left_start_r  <= '0;
      right_start_r <= '0;
      cross_cnt_r   <= '0;
      end_cnt_r     <= '0;
    end else if (in_take) begin
      seg_idx_r     <= seg_idx_nxt;
      seg_mark_r    <= seg_mark_nxt;
      left_start_r  <= left_start_nxt;
      right_start_r <= right_start_nxt;
      cross_cnt_r   <= cross_cnt_nxt;
      end_cnt_r     <= end_cnt_nxt;
    end
  end

  // valid flag: set on a new sample, drop once the entry is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: load with each accepted sample, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.record_write       = result_r.record_write;
  assign out_ch.record_slot        = result_r.record_slot;
  assign out_ch.left_delta         = result_r.left_delta;
  assign out_ch.right_delta        = result_r.right_delta;
  assign out_ch.crossings_at_close = result_r.crossings_at_close;
  assign out_ch.cross_write        = result_r.cross_write;
  assign out_ch.cross_slot         = result_r.cross_slot;
  assign out_ch.cross_segment      = result_r.cross_segment;
  assign out_ch.effective_mark     = result_r.effective_mark;
  assign out_ch.end_marks_seen     = result_r.end_marks_seen;
  assign out_ch.overflow           = result_r.overflow;

endmodule
`default_nettype wire
